@@ src/hybrid_merge_sort_macros.svh @@
`ifndef HYBRID_MERGE_SORT_MACROS_SVH
`define HYBRID_MERGE_SORT_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define HMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define HMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/hms_pkg.sv @@
package hms_pkg;

  localparam int VALUE_W       = 32;
  localparam int HMS_MAX_ITEMS = 64;

  typedef enum logic [1:0] {
    WR_IN,
    WR_A,
    WR_B
  } wr_src_t;

  typedef struct packed {
    logic    in_ready;
    logic    wr;
    logic    wr_mem;
    wr_src_t wr_src;
    logic    rd_mem;
    logic    out_load;
    logic    out_last;
    logic    out_ovf;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic a_le_b;
    logic out_free;
  } sts_t;

endpackage

@@ src/hms_if.sv @@
interface hms_in_if;
  import hms_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface hms_out_if;
  import hms_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_res;
  logic                      last_res;
  logic                      overflow;
  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

@@ src/hybrid_merge_sort.sv @@
// Stable ascending sort of up to MAX_ITEMS signed 32-bit values. Items are taken one per
// cycle into the element store; the item marked last (also if dropped because the store is
// full, which sets overflow on every result of the set) starts a bottom-up merge sort that
// ping-pongs between the element and scratch stores. Each merged element takes a registered
// two-port read followed by a compare and write, and each run and each pass adds a setup
// state of its own. Results then leave one at a time through an output register, each read
// from the store and then loaded once the register is free; the next set may start loading
// while the final result waits.
module hybrid_merge_sort #(
  parameter int MAX_ITEMS = hms_pkg::HMS_MAX_ITEMS
) (
  input logic       clk,
  input logic       rst,
  hms_in_if.sink    din,
  hms_out_if.source dout
);
  import hms_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic [AW-1:0] wa;

  hms_ctrl #(.MAX_ITEMS(MAX_ITEMS)) u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd),
    .ra  (ra),
    .rb  (rb),
    .wa  (wa)
  );

  hms_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cmd  (cmd),
    .ra   (ra),
    .rb   (rb),
    .wa   (wa),
    .sts  (sts)
  );

endmodule

@@ src/hms_datapath.sv @@
module hms_datapath #(
  parameter int MAX_ITEMS = hms_pkg::HMS_MAX_ITEMS,
  localparam int AW = $clog2(MAX_ITEMS)
) (
  input  logic          clk,
  input  logic          rst,
  hms_in_if.sink        din,
  hms_out_if.source     dout,
  input  hms_pkg::cmd_t cmd,
  input  logic [AW-1:0] ra,
  input  logic [AW-1:0] rb,
  input  logic [AW-1:0] wa,
  output hms_pkg::sts_t sts
);
  import hms_pkg::*;

  logic signed [VALUE_W-1:0] mem0 [MAX_ITEMS];
  logic signed [VALUE_W-1:0] mem1 [MAX_ITEMS];
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;
  logic signed [VALUE_W-1:0] wdata;
  logic                      out_valid;

  always_comb begin
    unique case (cmd.wr_src)
      WR_IN:   wdata = din.value;
      WR_A:    wdata = rd_a;
      WR_B:    wdata = rd_b;
      default: wdata = rd_b;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && !cmd.wr_mem) begin
      mem0[wa] <= wdata;
    end
    if (cmd.wr && cmd.wr_mem) begin
      mem1[wa] <= wdata;
    end
    rd_a <= cmd.rd_mem ? mem1[ra] : mem0[ra];
    rd_b <= cmd.rd_mem ? mem1[rb] : mem0[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dout.value_res <= rd_a;
      dout.last_res  <= cmd.out_last;
      dout.overflow  <= cmd.out_ovf;
    end
  end

  assign dout.valid   = out_valid;
  assign din.ready    = cmd.in_ready;
  assign sts.in_valid = din.valid;
  assign sts.in_last  = din.last;
  assign sts.a_le_b   = (rd_a <= rd_b);
  assign sts.out_free = !out_valid || dout.ready;

endmodule

@@ src/hms_ctrl.sv @@
`include "hybrid_merge_sort_macros.svh"

module hms_ctrl #(
  parameter int MAX_ITEMS = hms_pkg::HMS_MAX_ITEMS,
  localparam int AW = $clog2(MAX_ITEMS),
  localparam int CW = $clog2(MAX_ITEMS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  hms_pkg::sts_t sts,
  output hms_pkg::cmd_t cmd,
  output logic [AW-1:0] ra,
  output logic [AW-1:0] rb,
  output logic [AW-1:0] wa
);
  import hms_pkg::*;

  typedef enum logic [2:0] {
    LOAD,
    PASS_START,
    RUN_START,
    MERGE_RD,
    MERGE_WR,
    EMIT_RD,
    EMIT_PUT
  } state_t;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  state_t        state;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic          src_sel;
  logic [CW:0]   width;
  logic [CW-1:0] lo;
  logic [CW-1:0] mid;
  logic [CW-1:0] hi;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] k;

  logic          accept;
  logic          room;
  logic          take_a;
  logic [CW+1:0] sum_mid;
  logic [CW+1:0] sum_hi;
  logic [CW-1:0] k_inc;

  assign accept  = sts.in_valid && cmd.in_ready;
  assign room    = (cnt < MAX_CNT);
  assign take_a  = (i < mid) && ((j >= hi) || sts.a_le_b);
  assign sum_mid = (CW+2)'(lo) + (CW+2)'(width);
  assign sum_hi  = (CW+2)'(lo) + ((CW+2)'(width) << 1);
  assign k_inc   = k + 1'b1;

  always_comb begin
    cmd          = '0;
    cmd.wr_src   = WR_IN;
    cmd.rd_mem   = src_sel;
    cmd.wr_mem   = ~src_sel;
    cmd.out_last = (k_inc == cnt);
    cmd.out_ovf  = ovf;
    ra           = i[AW-1:0];
    rb           = j[AW-1:0];
    wa           = k[AW-1:0];
    unique case (state)
      LOAD: begin
        cmd.in_ready = 1'b1;
        cmd.wr       = accept && room;
        cmd.wr_mem   = 1'b0;
        wa           = cnt[AW-1:0];
      end
      MERGE_WR: begin
        cmd.wr     = 1'b1;
        cmd.wr_src = take_a ? WR_A : WR_B;
      end
      EMIT_RD, EMIT_PUT: begin
        ra           = k[AW-1:0];
        cmd.out_load = (state == EMIT_PUT) && sts.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= LOAD;
      cnt     <= '0;
      ovf     <= 1'b0;
      src_sel <= 1'b0;
      width   <= '0;
    end else begin
      unique case (state)
        LOAD: begin
          if (accept) begin
            if (room) begin
              cnt <= cnt + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (sts.in_last) begin
              width <= (CW+1)'(1);
              state <= PASS_START;
            end
          end
        end
        PASS_START: begin
          lo <= '0;
          k  <= '0;
          if (width < (CW+1)'(cnt)) begin
            state <= RUN_START;
          end else begin
            state <= EMIT_RD;
          end
        end
        RUN_START: begin
          mid   <= (sum_mid > (CW+2)'(cnt)) ? cnt : sum_mid[CW-1:0];
          hi    <= (sum_hi > (CW+2)'(cnt)) ? cnt : sum_hi[CW-1:0];
          i     <= lo;
          j     <= (sum_mid > (CW+2)'(cnt)) ? cnt : sum_mid[CW-1:0];
          k     <= lo;
          state <= MERGE_RD;
        end
        MERGE_RD: begin
          state <= MERGE_WR;
        end
        MERGE_WR: begin
          if (take_a) begin
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
          k <= k_inc;
          if (k_inc != hi) begin
            state <= MERGE_RD;
          end else if (hi != cnt) begin
            lo    <= hi;
            state <= RUN_START;
          end else begin
            width   <= width << 1;
            src_sel <= ~src_sel;
            state   <= PASS_START;
          end
        end
        EMIT_RD: begin
          state <= EMIT_PUT;
        end
        EMIT_PUT: begin
          if (sts.out_free) begin
            k <= k_inc;
            if (k_inc == cnt) begin
              cnt     <= '0;
              ovf     <= 1'b0;
              src_sel <= 1'b0;
              state   <= LOAD;
            end else begin
              state <= EMIT_RD;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  `HMS_ASSERT_NEXT(a_last_starts_sort, accept && sts.in_last, state != LOAD, "last item did not start the sort")
  `HMS_ASSERT_NOW(a_sort_not_empty, state == PASS_START, cnt != '0, "sort pass with an empty set")
  `HMS_ASSERT_NOW(a_merge_in_run, state == MERGE_WR, (k < hi) && ((i < mid) || (j < hi)), "merge write outside its run")
  `HMS_ASSERT_NOW(a_merge_balance, state == MERGE_WR, (CW+1)'(k) + (CW+1)'(mid) == (CW+1)'(i) + (CW+1)'(j), "merge indices out of step")
  `HMS_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, sts.out_free, "pending result overwritten")

endmodule
